// ===== hdl/mlc_pkg.sv =====
`default_nettype none

package mlc_pkg;

  // result kinds
  localparam logic [2:0] KIND_EMPTY   = 3'd0;
  localparam logic [2:0] KIND_COMMAND = 3'd1;
  localparam logic [2:0] KIND_TARGET  = 3'd2;
  localparam logic [2:0] KIND_MACRO   = 3'd3;
  localparam logic [2:0] KIND_APPEND  = 3'd4;
  localparam logic [2:0] KIND_INCLUDE = 3'd5;
  localparam logic [2:0] KIND_ERROR   = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNEXP_END = 3'd1;
  localparam logic [2:0] ERR_BAD_EXPAN = 3'd2;
  localparam logic [2:0] ERR_SCOPE_TGT = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_AT     = 8'h40;

  // "include " spelled out
  localparam logic [7:0] INCL_WORD [8] = '{8'h69, 8'h6E, 8'h63, 8'h6C,
                                          8'h75, 8'h64, 8'h65, 8'h20};
  localparam logic [3:0] PREFIX_FULL = 4'd8;
  localparam logic [3:0] PREFIX_FAIL = 4'd15;

  // result queue between classifier and output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  error_code;
    logic        has_scope;
    logic [11:0] scope_end;
    logic [11:0] name_start;
    logic [11:0] name_end;
    logic [12:0] value_start;
    logic [11:0] error_pos;
  } mlc_res_t;

  typedef struct packed {
    logic     valid;
    mlc_res_t res;
  } mlc_head_t;

endpackage

`default_nettype wire

// ===== hdl/mlc_front.sv =====
`default_nettype none

module mlc_front #(
  parameter int MAX_LINE = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire logic [7:0]       ch,
  input  wire logic             eol,
  output mlc_pkg::mlc_res_t     res,
  output logic                  hit
);
  import mlc_pkg::*;

  localparam int PW = $clog2(MAX_LINE + 1);

  typedef enum logic [4:0] {
    M_START  = 5'b00001,
    M_READ   = 5'b00010,
    M_DOLLAR = 5'b00100,
    M_FULL   = 5'b01000,
    M_IGNORE = 5'b10000
  } mode_t;

  typedef enum logic [2:0] {
    P_NONE  = 3'b001,
    P_COLON = 3'b010,
    P_PLUS  = 3'b100
  } pend_t;

  mode_t          mode_r, mode_nxt;
  pend_t          pend_r, pend_nxt;
  logic [PW-1:0]  depth_r, depth_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic [PW-1:0]  nbeg_r, nbeg_nxt;
  logic [PW-1:0]  slen_r, slen_nxt;
  logic           sseen_r, sseen_nxt;
  logic [3:0]     pm_r, pm_nxt;

  logic [PW-1:0]  pos_m1, pos_p1, k_cur, k_prev;
  logic           ovf_cur, ovf_prev;
  logic [3:0]     pm_in;
  logic           rd_char, do_store, do_end;

  function automatic logic [3:0] prefix_upd(logic [3:0] pm, logic [7:0] c,
                                            logic [PW-1:0] k);
    logic [3:0] r;
    r = pm;
    if (k < PW'(8) && pm != PREFIX_FAIL) begin
      if (pm == {1'b0, k[2:0]} && c == INCL_WORD[k[2:0]]) begin
        r = {1'b0, k[2:0]} + 4'd1;
      end else begin
        r = PREFIX_FAIL;
      end
    end
    return r;
  endfunction

  assign pos_m1   = pos_r - PW'(1);
  assign pos_p1   = pos_r + PW'(1);
  assign k_cur    = pos_r - nbeg_r;
  assign k_prev   = pos_m1 - nbeg_r;
  assign ovf_cur  = k_cur >= PW'(MAX_LINE - 1);
  assign ovf_prev = k_prev >= PW'(MAX_LINE - 1);

  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    depth_nxt = depth_r;
    pos_nxt   = pos_r;
    nbeg_nxt  = nbeg_r;
    slen_nxt  = slen_r;
    sseen_nxt = sseen_r;
    pm_nxt    = pm_r;
    hit       = 1'b0;
    res       = '0;
    pm_in     = pm_r;
    rd_char   = 1'b0;
    do_store  = 1'b0;
    do_end    = 1'b0;

    if (mode_r == M_IGNORE) begin
      hit = 1'b0;
    end else if (mode_r == M_START) begin
      if (eol || ch == CH_HASH) begin
        hit      = 1'b1;
        res.kind = KIND_EMPTY;
      end else if (ch == CH_TAB) begin
        hit             = 1'b1;
        res.kind        = KIND_COMMAND;
        res.value_start = 13'd1;
      end else begin
        mode_nxt = M_READ;
        rd_char  = 1'b1;
      end
    end else if (!eol && pos_r >= PW'(MAX_LINE)) begin
      hit            = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = ERR_OVERFLOW;
      res.error_pos  = 12'(MAX_LINE - 1);
    end else begin
      case (mode_r)
        M_READ: begin
          if (pend_r == P_COLON) begin
            pend_nxt = P_NONE;
            if (!eol && ch == CH_EQUAL) begin
              sseen_nxt = 1'b1;
              slen_nxt  = pos_m1;
              nbeg_nxt  = pos_p1;
              pm_nxt    = 4'd0;
            end else if (sseen_r) begin
              hit            = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_SCOPE_TGT;
              res.has_scope  = 1'b1;
              res.scope_end  = 12'(slen_r);
              res.error_pos  = 12'(pos_m1);
            end else begin
              hit             = 1'b1;
              res.kind        = KIND_TARGET;
              res.name_start  = 12'(nbeg_r);
              res.name_end    = 12'(pos_m1);
              res.value_start = 13'(pos_r);
            end
          end else if (pend_r == P_PLUS) begin
            pend_nxt = P_NONE;
            if (!eol && ch == CH_EQUAL) begin
              hit             = 1'b1;
              res.kind        = KIND_APPEND;
              res.has_scope   = sseen_r;
              res.scope_end   = sseen_r ? 12'(slen_r) : 12'd0;
              res.name_start  = 12'(nbeg_r);
              res.name_end    = 12'(pos_m1);
              res.value_start = 13'(pos_p1);
            end else if (ovf_prev) begin
              hit            = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_OVERFLOW;
              res.error_pos  = 12'(pos_m1);
            end else begin
              // the held '+' joins the name, then this item goes on as usual
              pm_in   = prefix_upd(pm_r, CH_PLUS, k_prev);
              pm_nxt  = pm_in;
              do_end  = eol;
              rd_char = !eol;
            end
          end else begin
            do_end  = eol;
            rd_char = !eol;
          end
        end
        M_DOLLAR: begin
          if (eol || ch == CH_HASH) begin
            hit            = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_UNEXP_END;
            res.error_pos  = 12'(pos_m1);
          end else if (ch == CH_LPAREN || ch == CH_AT) begin
            if (ovf_prev) begin
              hit            = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_OVERFLOW;
              res.error_pos  = 12'(pos_m1);
            end else begin
              pm_in    = prefix_upd(pm_r, CH_DOLLAR, k_prev);
              do_store = 1'b1;
              if (ch == CH_LPAREN) begin
                mode_nxt  = M_FULL;
                depth_nxt = PW'(1);
              end else begin
                mode_nxt = M_READ;
              end
            end
          end else begin
            hit            = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_BAD_EXPAN;
            res.error_pos  = 12'(pos_m1);
          end
        end
        M_FULL: begin
          if (eol || ch == CH_HASH) begin
            hit            = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_UNEXP_END;
            res.error_pos  = 12'(pos_r);
          end else begin
            if (ch == CH_LPAREN) begin
              depth_nxt = depth_r + PW'(1);
            end else if (ch == CH_RPAREN && depth_r != '0) begin
              depth_nxt = depth_r - PW'(1);
              if (depth_r == PW'(1)) begin
                mode_nxt = M_READ;
              end
            end
            do_store = 1'b1;
          end
        end
        default: begin
          hit = 1'b0;
        end
      endcase
    end

    if (rd_char) begin
      case (ch)
        CH_HASH: begin
          do_end = 1'b1;
        end
        CH_COLON: begin
          pend_nxt = P_COLON;
        end
        CH_PLUS: begin
          pend_nxt = P_PLUS;
        end
        CH_EQUAL: begin
          hit             = 1'b1;
          res.kind        = KIND_MACRO;
          res.has_scope   = sseen_r;
          res.scope_end   = sseen_r ? 12'(slen_r) : 12'd0;
          res.name_start  = 12'(nbeg_r);
          res.name_end    = 12'(pos_r);
          res.value_start = 13'(pos_p1);
        end
        CH_DOLLAR: begin
          mode_nxt = M_DOLLAR;
        end
        default: begin
          do_store = 1'b1;
        end
      endcase
    end

    if (do_store) begin
      if (ovf_cur) begin
        hit            = 1'b1;
        res.kind       = KIND_ERROR;
        res.error_code = ERR_OVERFLOW;
        res.error_pos  = 12'(pos_r);
      end else begin
        pm_nxt = prefix_upd(pm_in, ch, k_cur);
      end
    end

    if (do_end) begin
      hit = 1'b1;
      if (pm_in == PREFIX_FULL) begin
        res.kind       = KIND_INCLUDE;
        res.name_start = 12'(nbeg_r + PW'(8));
        res.name_end   = 12'(pos_r);
      end else begin
        res.kind       = KIND_ERROR;
        res.error_code = ERR_UNEXP_END;
        res.error_pos  = 12'(pos_r);
      end
    end

    if (eol) begin
      mode_nxt  = M_START;
      pend_nxt  = P_NONE;
      depth_nxt = '0;
      pos_nxt   = '0;
      nbeg_nxt  = '0;
      slen_nxt  = '0;
      sseen_nxt = 1'b0;
      pm_nxt    = 4'd0;
    end else if (mode_r != M_IGNORE) begin
      if (hit) begin
        mode_nxt = M_IGNORE;
      end else begin
        pos_nxt = pos_p1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_START;
      pend_r  <= P_NONE;
      depth_r <= '0;
      pos_r   <= '0;
      nbeg_r  <= '0;
      slen_r  <= '0;
      sseen_r <= 1'b0;
      pm_r    <= 4'd0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      depth_r <= depth_nxt;
      pos_r   <= pos_nxt;
      nbeg_r  <= nbeg_nxt;
      slen_r  <= slen_nxt;
      sseen_r <= sseen_nxt;
      pm_r    <= pm_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mlc_queue.sv =====
`default_nettype none

module mlc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire mlc_pkg::mlc_res_t  push_res,
  input  wire logic               pop,
  output mlc_pkg::mlc_head_t      head,
  output logic [mlc_pkg::QCW-1:0] count
);
  import mlc_pkg::*;

  mlc_res_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_res;
    end
  end

  assign head.valid = count_r != '0;
  assign head.res   = mem_r[rd_ptr_r];
  assign count      = count_r;

endmodule

`default_nettype wire

// ===== hdl/mlc_back.sv =====
`default_nettype none

module mlc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mlc_pkg::mlc_head_t head,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mlc_pkg::mlc_res_t       out_res
);
  import mlc_pkg::*;

  logic     vld_r;
  mlc_res_t res_r;

  // refill whenever the output register is empty or its transfer completes
  assign pop = head.valid && (!vld_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (pop) begin
      vld_r <= 1'b1;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head.res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ===== hdl/make_line_classifier_core.sv =====
`default_nettype none

// Makefile line classifier. Characters of one line arrive one per transfer,
// the line closed by a transfer with in_end_of_line set. At the character
// that decides the line, one result comes out: its kind and the positions of
// scope, name and value, or an error code and position. Later characters of
// that line are dropped and the end-of-line transfer readies the block for
// the next line. One character is taken per cycle while in_stall is low; the
// classifier registers its mode, counters and include-prefix match, and
// results pass through a four-entry queue into an output register: each
// result is written to the queue and then to that register. in_stall rises
// only while that queue is full because the output side is stalled.
module make_line_classifier_core #(
  parameter int MAX_LINE = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_end_of_line,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [2:0]       out_error_code,
  output logic             out_has_scope,
  output logic [11:0]      out_scope_end,
  output logic [11:0]      out_name_start,
  output logic [11:0]      out_name_end,
  output logic [12:0]      out_value_start,
  output logic [11:0]      out_error_pos
);
  import mlc_pkg::*;

  logic            in_acc;
  logic            hit;
  logic            push;
  logic            pop;
  mlc_res_t        front_res;
  mlc_res_t        out_res;
  mlc_head_t       head;
  logic [QCW-1:0]  q_count;

  assign in_stall = q_count == QCW'(QDEPTH);
  assign in_acc   = in_valid && !in_stall;
  assign push     = in_acc && hit;

  mlc_front #(
    .MAX_LINE(MAX_LINE)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (in_acc),
    .ch    (in_ch),
    .eol   (in_end_of_line),
    .res   (front_res),
    .hit   (hit)
  );

  mlc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_res (front_res),
    .pop      (pop),
    .head     (head),
    .count    (q_count)
  );

  mlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_error_code  = out_res.error_code;
  assign out_has_scope   = out_res.has_scope;
  assign out_scope_end   = out_res.scope_end;
  assign out_name_start  = out_res.name_start;
  assign out_name_end    = out_res.name_end;
  assign out_value_start = out_res.value_start;
  assign out_error_pos   = out_res.error_pos;

`ifndef ASSERT_OFF
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ((front_res.kind == KIND_ERROR) == (front_res.error_code != ERR_NONE)))
    else $error("error code and error kind disagree");

  a_scope_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (push && front_res.has_scope) |-> (front_res.kind == KIND_MACRO ||
      front_res.kind == KIND_APPEND || front_res.kind == KIND_ERROR))
    else $error("scope flagged on a kind that has none");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCW'(QDEPTH))
    else $error("result queue overfilled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == '0 && !push) |=> !pop)
    else $error("output stage pulled from an empty queue");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_make_line_classifier_core.sv =====
module tb_make_line_classifier_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mlc_pkg::*;

  localparam int LINE_MAX = 4096;
  localparam string NAME_CHARS = "abcdefghijklmnopqrstuvwxyz_./-0123456789 ";

  typedef enum logic [2:0] {M_START, M_READ, M_DOLLAR, M_EXPAND, M_SKIP} line_mode_e;
  typedef enum logic [1:0] {P_NONE, P_COLON, P_PLUS} sep_wait_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'h00;
  logic        in_end_of_line = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [2:0]  out_error_code;
  logic        out_has_scope;
  logic [11:0] out_scope_end;
  logic [11:0] out_name_start;
  logic [11:0] out_name_end;
  logic [12:0] out_value_start;
  logic [11:0] out_error_pos;

  make_line_classifier_core #(.MAX_LINE(LINE_MAX)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_end_of_line (in_end_of_line),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_error_code (out_error_code),
    .out_has_scope  (out_has_scope),
    .out_scope_end  (out_scope_end),
    .out_name_start (out_name_start),
    .out_name_end   (out_name_end),
    .out_value_start(out_value_start),
    .out_error_pos  (out_error_pos)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // classifier state mirrored by the testbench
  line_mode_e line_mode = M_START;
  sep_wait_e  sep_wait = P_NONE;
  int         depth = 0;
  int         line_idx = 0;
  int         name_base = 0;
  int         scope_len = 0;
  bit         scope_on = 1'b0;
  int         incl_match = 0;

  mlc_res_t   expected_classes[$];
  mlc_res_t   due;
  logic [7:0] line_buf[$];
  int         fail_count = 0;
  int         live_items = 0;
  bit         idle_en = 1'b0;
  int         stall_left = 0;

  function automatic void clear_line();
    line_mode = M_START;
    sep_wait = P_NONE;
    depth = 0;
    line_idx = 0;
    name_base = 0;
    scope_len = 0;
    scope_on = 1'b0;
    incl_match = 0;
  endfunction

  function automatic mlc_res_t make_res(logic [2:0] k, logic [2:0] e, bit hs, int se, int ns,
                                        int ne, int vs, int ep);
    mlc_res_t r;
    r.kind = k;
    r.error_code = e;
    r.has_scope = hs;
    r.scope_end = hs ? se[11:0] : 12'd0;
    r.name_start = ns[11:0];
    r.name_end = ne[11:0];
    r.value_start = vs[12:0];
    r.error_pos = ep[11:0];
    return r;
  endfunction

  function automatic mlc_res_t err_res(logic [2:0] e, int ep);
    return make_res(KIND_ERROR, e, 1'b0, 0, 0, 0, 0, ep);
  endfunction

  function automatic bit keep_name_char(logic [7:0] c, int pos, output mlc_res_t r);
    int k;
    r = '0;
    k = pos - name_base;
    if (k >= LINE_MAX - 1) begin
      r = err_res(ERR_OVERFLOW, pos);
      return 1'b1;
    end
    if (k < 8 && incl_match != PREFIX_FAIL) begin
      if (incl_match == k && c == INCL_WORD[k]) incl_match = k + 1;
      else incl_match = PREFIX_FAIL;
    end
    return 1'b0;
  endfunction

  function automatic bit finish_name(int pos, output mlc_res_t r);
    if (incl_match == PREFIX_FULL)
      r = make_res(KIND_INCLUDE, ERR_NONE, 1'b0, 0, name_base + 8, pos, 0, 0);
    else
      r = err_res(ERR_UNEXP_END, pos);
    return 1'b1;
  endfunction

  function automatic bit scan_char(logic [7:0] c, int pos, output mlc_res_t r);
    r = '0;
    if (c == CH_HASH) return finish_name(pos, r);
    if (c == CH_COLON) begin
      sep_wait = P_COLON;
      return 1'b0;
    end
    if (c == CH_PLUS) begin
      sep_wait = P_PLUS;
      return 1'b0;
    end
    if (c == CH_EQUAL) begin
      r = make_res(KIND_MACRO, ERR_NONE, scope_on, scope_len, name_base, pos, pos + 1, 0);
      return 1'b1;
    end
    if (c == CH_DOLLAR) begin
      line_mode = M_DOLLAR;
      return 1'b0;
    end
    return keep_name_char(c, pos, r);
  endfunction

  function automatic bit expansion_char(logic [7:0] c, int pos, output mlc_res_t r);
    if (c == CH_LPAREN) begin
      depth++;
    end else if (c == CH_RPAREN && depth > 0) begin
      depth--;
      if (depth == 0) line_mode = M_READ;
    end
    return keep_name_char(c, pos, r);
  endfunction

  // Advances the mirrored state by one transfer; returns 1 when the line is decided.
  function automatic bit classify_char(logic [7:0] c, logic eol, output mlc_res_t r);
    int pos;
    bit hit;
    bit go_on;
    pos = line_idx;
    hit = 1'b0;
    go_on = 1'b1;
    r = '0;
    if (line_mode == M_SKIP) begin
      if (eol) clear_line();
      return 1'b0;
    end
    if (line_mode == M_START) begin
      if (eol || c == CH_HASH) begin
        r = make_res(KIND_EMPTY, ERR_NONE, 1'b0, 0, 0, 0, 0, 0);
        hit = 1'b1;
      end else if (c == CH_TAB) begin
        r = make_res(KIND_COMMAND, ERR_NONE, 1'b0, 0, 0, 0, 1, 0);
        hit = 1'b1;
      end else begin
        line_mode = M_READ;
        hit = scan_char(c, pos, r);
      end
    end else if (!eol && pos >= LINE_MAX) begin
      r = err_res(ERR_OVERFLOW, LINE_MAX - 1);
      hit = 1'b1;
    end else if (line_mode == M_READ) begin
      if (sep_wait == P_COLON) begin
        sep_wait = P_NONE;
        if (!eol && c == CH_EQUAL) begin
          scope_on = 1'b1;
          scope_len = pos - 1;
          name_base = pos + 1;
          incl_match = 0;
        end else if (scope_on) begin
          r = make_res(KIND_ERROR, ERR_SCOPE_TGT, 1'b1, scope_len, 0, 0, 0, pos - 1);
          hit = 1'b1;
        end else begin
          r = make_res(KIND_TARGET, ERR_NONE, 1'b0, 0, name_base, pos - 1, pos, 0);
          hit = 1'b1;
        end
      end else begin
        if (sep_wait == P_PLUS) begin
          sep_wait = P_NONE;
          if (!eol && c == CH_EQUAL) begin
            r = make_res(KIND_APPEND, ERR_NONE, scope_on, scope_len, name_base, pos - 1,
                         pos + 1, 0);
            hit = 1'b1;
            go_on = 1'b0;
          end else begin
            // a lone '+' belongs to the name
            hit = keep_name_char(CH_PLUS, pos - 1, r);
            go_on = !hit;
          end
        end
        if (go_on) begin
          if (eol) hit = finish_name(pos, r);
          else hit = scan_char(c, pos, r);
        end
      end
    end else if (line_mode == M_DOLLAR) begin
      if (eol || c == CH_HASH) begin
        r = err_res(ERR_UNEXP_END, pos - 1);
        hit = 1'b1;
      end else if (c == CH_LPAREN || c == CH_AT) begin
        hit = keep_name_char(CH_DOLLAR, pos - 1, r);
        if (!hit) begin
          if (c == CH_LPAREN) begin
            line_mode = M_EXPAND;
            depth = 0;
            hit = expansion_char(c, pos, r);
          end else begin
            line_mode = M_READ;
            hit = scan_char(c, pos, r);
          end
        end
      end else begin
        r = err_res(ERR_BAD_EXPAN, pos - 1);
        hit = 1'b1;
      end
    end else begin
      if (eol || c == CH_HASH) begin
        r = err_res(ERR_UNEXP_END, pos);
        hit = 1'b1;
      end else begin
        hit = expansion_char(c, pos, r);
      end
    end

    if (eol) clear_line();
    else if (hit) line_mode = M_SKIP;
    else line_idx = pos + 1;
    return hit;
  endfunction

  // One transfer on the input channel, with an occasional idle burst ahead of it.
  task automatic send_char(logic [7:0] c, logic eol);
    mlc_res_t r;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ch <= c;
    in_end_of_line <= eol;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (line_mode != M_SKIP) live_items++;
    if (classify_char(c, eol, r)) expected_classes.push_back(r);
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] name_byte();
    return NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)];
  endfunction

  task automatic send_buffer();
    foreach (line_buf[i]) send_char(line_buf[i], 1'b0);
    send_char(rand_byte(), 1'b1);
    line_buf.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_buffer();
  endtask

  task automatic add_noise(int most);
    repeat ($urandom_range(0, most)) begin
      if ($urandom_range(0, 2) == 0) line_buf.push_back(rand_byte());
      else line_buf.push_back(name_byte());
    end
  endtask

  task automatic add_expansion();
    line_buf.push_back(CH_DOLLAR);
    line_buf.push_back(CH_LPAREN);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) begin
        line_buf.push_back(CH_LPAREN);
        line_buf.push_back(name_byte());
        line_buf.push_back(CH_RPAREN);
      end else begin
        line_buf.push_back(name_byte());
      end
    end
    if ($urandom_range(0, 9) != 0) line_buf.push_back(CH_RPAREN);
  endtask

  task automatic add_name();
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0: begin
          line_buf.push_back(CH_DOLLAR);
          line_buf.push_back(CH_AT);
        end
        1: add_expansion();
        2: line_buf.push_back(CH_PLUS);
        3: begin
          line_buf.push_back(CH_DOLLAR);
          line_buf.push_back(rand_byte());
        end
        4: line_buf.push_back(rand_byte());
        default: line_buf.push_back(name_byte());
      endcase
    end
  endtask

  task automatic add_include();
    string word;
    word = "include ";
    if ($urandom_range(0, 3) == 0) word[$urandom_range(0, 7)] = name_byte();
    for (int i = 0; i < word.len(); i++) line_buf.push_back(word[i]);
  endtask

  // Mostly well-formed makefile lines with random content, some noise.
  task automatic send_random_line();
    int shape;
    shape = $urandom_range(0, 19);
    if (shape < 2) begin
      repeat ($urandom_range(1, 12)) line_buf.push_back(rand_byte());
    end else if (shape < 4) begin
      case ($urandom_range(0, 2))
        0: line_buf.push_back(CH_HASH);
        1: line_buf.push_back(CH_TAB);
        default: ;
      endcase
      add_noise(3);
    end else begin
      if ($urandom_range(0, 4) == 0) add_include();
      repeat ($urandom_range(0, 2)) begin
        add_name();
        line_buf.push_back(CH_COLON);
        line_buf.push_back(CH_EQUAL);
      end
      add_name();
      case ($urandom_range(0, 5))
        0: line_buf.push_back(CH_EQUAL);
        1: begin
          line_buf.push_back(CH_PLUS);
          line_buf.push_back(CH_EQUAL);
        end
        2: line_buf.push_back(CH_COLON);
        3: line_buf.push_back(CH_HASH);
        4: ;
        default: line_buf.push_back(rand_byte());
      endcase
      add_noise(5);
    end
    send_buffer();
  endtask

  task automatic test_directed();
    idle_en = 1'b1;
    send_text("");
    send_text("# note");
    send_text("\tcc -c x.c");
    send_text("all: x.o");
    send_text("a:");
    send_text("CC = gcc");
    send_text("x=");
    send_text("x += -O2");
    send_text("a+b=1");
    send_text("x+");
    send_text("include rules.mk");
    send_text("include ");
    send_text("includ");
    send_text("inclUde x");
    send_text("S:=N=v");
    send_text("s:=t:=n+=v");
    send_text("s:=t: dep");
    send_text("$(CC)=x");
    send_text("$@:x");
    send_text("$(a(b)c)d=1 # dropped");
    send_text("$x");
    send_text("$#");
    send_text("$");
    send_text("$(abc");
    send_text("$(ab#");
    send_text("a#");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    line_buf.push_back(CH_EQUAL);
    send_buffer();
  endtask

  task automatic test_long_lines();
    // '=' at the last position: value starts one past the line limit
    repeat (LINE_MAX - 1) line_buf.push_back(name_byte());
    line_buf.push_back(CH_EQUAL);
    send_buffer();
    // name grows past its limit
    repeat (LINE_MAX + 2) line_buf.push_back(name_byte());
    send_buffer();
    // scope moves the name start, so the line limit trips first
    line_buf.push_back(8'h61);
    line_buf.push_back(CH_COLON);
    line_buf.push_back(CH_EQUAL);
    repeat (LINE_MAX - 2) line_buf.push_back(name_byte());
    send_buffer();
  endtask

  task automatic test_random_lines(int target);
    live_items = 0;
    while (live_items < target) begin
      idle_en = ($urandom_range(0, 4) != 0);
      send_random_line();
    end
  endtask

  task automatic test_full_rate(int target);
    idle_en = 1'b0;
    live_items = 0;
    while (live_items < target) send_random_line();
  endtask

  task automatic check_field(string fld, logic [12:0] want, logic [12:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", fld, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_classes.size() == 0) begin
        $error("out_kind: expected no transfer, actual %0d", out_kind);
        fail_count++;
      end else begin
        due = expected_classes.pop_front();
        check_field("out_kind", due.kind, out_kind);
        check_field("out_error_code", due.error_code, out_error_code);
        check_field("out_has_scope", due.has_scope, out_has_scope);
        check_field("out_scope_end", due.scope_end, out_scope_end);
        check_field("out_name_start", due.name_start, out_name_start);
        check_field("out_name_end", due.name_end, out_name_end);
        check_field("out_value_start", due.value_start, out_value_start);
        check_field("out_error_pos", due.error_pos, out_error_pos);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("tb_make_line_classifier_core NOT OK");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_lines();
    test_random_lines(1100);
    test_full_rate(150);
    in_valid <= 1'b0;
    while (expected_classes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_make_line_classifier_core OK");
    end else begin
      $display("tb_make_line_classifier_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mlc_pkg.sv
hdl/mlc_front.sv
hdl/mlc_queue.sv
hdl/mlc_back.sv
hdl/make_line_classifier_core.sv
verif/tb_make_line_classifier_core.sv
